>>> sv/thau_pkg.sv
// Package for the table heap allocator unit: table sizing, field widths,
// descriptor word layout and result codes. It depends on nothing else.
package thau_pkg;

	localparam int TABLE_ENTRIES = 16;
	localparam int POOL_BYTES = 65536;

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int BASE_W = 17;
	localparam int LEN_W = 16;
	localparam int SUM_W = BASE_W + 1;
	localparam int ADDR_W = 16;
	localparam int STATUS_W = 2;

	localparam logic [BASE_W-1:0] BASE_MAX = {BASE_W{1'b1}};
	localparam logic [SUM_W-1:0] POOL_LIM = SUM_W'(POOL_BYTES);
	localparam logic [IDX_W-1:0] LAST_WALK = IDX_W'(TABLE_ENTRIES - 2);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_FIT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

	typedef struct packed {
		logic [BASE_W-1:0] base;
		logic [LEN_W-1:0] length;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

>>> sv/thau_ram.sv
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. It depends on nothing else.
module thau_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> sv/table_heap_allocator_unit.sv
// Top level of the table heap allocator: first-fit allocate and free over a
// descriptor table held in one RAM. Depends on thau_pkg and thau_ram.
//
//   channel | valid     | stall     | payload
//   input   | in_valid  | in_stall  | kind, request_size, block_address
//   output  | out_valid | out_stall | status, granted_address
//
// An allocate fetches the first descriptor, then walks the descriptors one at
// a time (up to TABLE_ENTRIES - 1), then posts the result; a free searches
// the descriptors from the last one down, then posts its result. The walk
// is set by the single read port of the descriptor RAM. The free marks and
// the written marks live in flip-flops that reset sets or clears at once, so
// no clearing pass is needed. A waiting result does not block the next item;
// a finished item waits only while the output register is still full.
module table_heap_allocator_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          kind,
	input  logic [15:0]                   request_size,
	input  logic [15:0]                   block_address,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [thau_pkg::STATUS_W-1:0] status,
	output logic [15:0]                   granted_address
);
	import thau_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_LOAD = 3'd1;
	localparam logic [2:0] S_WALK = 3'd2;
	localparam logic [2:0] S_SRCH = 3'd3;
	localparam logic [2:0] S_POST = 3'd4;

	logic [2:0] state_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] rd_idx_q;
	logic [TABLE_ENTRIES-1:0] free_q;
	logic [TABLE_ENTRIES-1:0] written_q;
	logic [LEN_W-1:0] size_q;
	logic [ADDR_W-1:0] addr_q;
	logic [BASE_W-1:0] cur_base_q;
	logic [LEN_W-1:0] cur_len_q;
	logic [BASE_W-1:0] prev_end_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [ADDR_W-1:0] res_addr_q;

	logic [IDX_W-1:0] rd_addr;
	logic [ENTRY_W-1:0] ram_rdata;
	entry_t rd_entry;
	logic ram_we;
	entry_t wr_entry;

	logic in_accept;
	logic out_free;
	logic [IDX_W-1:0] idx_next;
	logic cur_free;
	logic [BASE_W-1:0] eff_base;
	logic [SUM_W-1:0] end_sum;
	logic [SUM_W-1:0] tail_sum;
	logic [BASE_W-1:0] tail_sat;
	logic fits;
	logic pool_ok;
	logic grant;
	logic match;

	thau_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_ENTRIES)
	) u_desc_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(idx_q),
		.wdata(wr_entry),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	assign in_accept = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid || !out_stall;
	assign idx_next = IDX_W'(idx_q + 1'b1);

	always_comb begin
		rd_entry = ram_rdata;
		if (!written_q[rd_idx_q]) begin
			rd_entry = '0;
		end
	end

	always_comb begin
		cur_free = free_q[idx_q];
		eff_base = cur_base_q;
		if (cur_free && (idx_q != '0)) begin
			eff_base = prev_end_q;
		end
		end_sum = SUM_W'(eff_base) + SUM_W'(size_q);
		fits = free_q[idx_next] || (SUM_W'(rd_entry.base) >= end_sum);
		pool_ok = (SUM_W'(eff_base) < POOL_LIM) && (end_sum <= POOL_LIM);
		grant = (state_q == S_WALK) && cur_free && fits && pool_ok;
		tail_sum = SUM_W'(eff_base) + SUM_W'(cur_len_q);
		tail_sat = tail_sum[SUM_W-1] ? BASE_MAX : tail_sum[BASE_W-1:0];
		match = !free_q[rd_idx_q] && (rd_entry.base == BASE_W'(addr_q));
		ram_we = (state_q == S_WALK) && cur_free;
		wr_entry.base = eff_base;
		wr_entry.length = grant ? size_q : cur_len_q;
	end

	always_comb begin
		case (state_q)
			S_IDLE: begin
				rd_addr = (kind == KIND_FREE) ? LAST_IDX : '0;
			end
			S_LOAD: begin
				rd_addr = idx_next;
			end
			S_WALK: begin
				rd_addr = IDX_W'(idx_q + 2'd2);
			end
			S_SRCH: begin
				rd_addr = IDX_W'(rd_idx_q - 1'b1);
			end
			default: begin
				rd_addr = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			size_q <= request_size;
			addr_q <= block_address;
		end
		if (state_q == S_LOAD) begin
			cur_base_q <= rd_entry.base;
			cur_len_q <= rd_entry.length;
		end
		if ((state_q == S_WALK) && !grant) begin
			cur_base_q <= rd_entry.base;
			cur_len_q <= rd_entry.length;
			prev_end_q <= tail_sat;
		end
		if (grant) begin
			res_status_q <= ST_DONE;
			res_addr_q <= eff_base[ADDR_W-1:0];
		end else if ((state_q == S_WALK) && (idx_q == LAST_WALK)) begin
			res_status_q <= ST_NO_FIT;
			res_addr_q <= '0;
		end
		if (state_q == S_SRCH) begin
			res_status_q <= match ? ST_DONE : ST_NOT_FOUND;
			res_addr_q <= '0;
		end
		if ((state_q == S_POST) && out_free) begin
			status <= res_status_q;
			granted_address <= res_addr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
			rd_idx_q <= '0;
			free_q <= '1;
			written_q <= '0;
			out_valid <= 1'b0;
		end else begin
			rd_idx_q <= rd_addr;
			if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			if (ram_we) begin
				written_q[idx_q] <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						idx_q <= '0;
						state_q <= (kind == KIND_FREE) ? S_SRCH : S_LOAD;
					end
				end
				S_LOAD: begin
					state_q <= S_WALK;
				end
				S_WALK: begin
					if (grant) begin
						free_q[idx_q] <= 1'b0;
						state_q <= S_POST;
					end else if (idx_q == LAST_WALK) begin
						state_q <= S_POST;
					end else begin
						idx_q <= idx_next;
					end
				end
				S_SRCH: begin
					if (match) begin
						free_q[rd_idx_q] <= 1'b1;
						state_q <= S_POST;
					end else if (rd_idx_q == '0) begin
						state_q <= S_POST;
					end
				end
				S_POST: begin
					if (out_free) begin
						out_valid <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> bench/table_heap_allocator_unit_tb.sv
`timescale 1ns / 1ps
// Testbench for table_heap_allocator_unit: a directed table, then random allocate and
// free traffic, each result checked against its fixed answer if known, else against
// a descriptor-table predictor in this file. Depends on thau_pkg and the allocator RTL.
module table_heap_allocator_unit_tb;

	import thau_pkg::*;

	localparam int RANDOM_ITEMS = 630;
	localparam int QUIET_ITEMS = 60;
	localparam int IDLE_LIMIT = 3000;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [15:0] granted;
	} alloc_result_t;

	typedef struct packed {
		logic known;
		alloc_result_t val;
	} known_answer_t;

	typedef struct packed {
		logic op;
		logic [15:0] req;
		logic [15:0] adr;
		logic known;
		logic [STATUS_W-1:0] st;
		logic [15:0] ga;
	} script_row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic kind;
	logic [15:0] request_size;
	logic [15:0] block_address;
	logic out_valid;
	logic out_stall;
	logic [STATUS_W-1:0] status;
	logic [15:0] granted_address;

	logic [BASE_W-1:0] desc_base [TABLE_ENTRIES];
	logic [LEN_W-1:0] desc_len [TABLE_ENTRIES];
	bit desc_free [TABLE_ENTRIES];

	alloc_result_t awaited_results[$];
	known_answer_t fixed_answers[$];
	int mismatch_count = 0;
	int results_seen = 0;
	int idle_cycles = 0;
	bit quiet_tail = 1'b0;
	bit sender_idles = 1'b1;

	// Fills four descriptors, frees them, then rebuilds the table so that the stale
	// lengths push a rewritten base past the 17-bit limit.
	script_row_t directed_script [23] = '{
		{KIND_FREE,  16'hFFFF, 16'h0000, 1'b1, ST_NOT_FOUND, 16'h0000},
		{KIND_ALLOC, 16'h0000, 16'hFFFF, 1'b1, ST_DONE,      16'h0000},
		{KIND_ALLOC, 16'h0000, 16'h0000, 1'b1, ST_DONE,      16'h0000},
		{KIND_ALLOC, 16'h0000, 16'h5555, 1'b1, ST_DONE,      16'h0000},
		{KIND_ALLOC, 16'hFFFF, 16'hAAAA, 1'b1, ST_DONE,      16'h0000},
		{KIND_FREE,  16'h0000, 16'h0000, 1'b1, ST_DONE,      16'h0000},
		{KIND_FREE,  16'h5555, 16'h0000, 1'b1, ST_DONE,      16'h0000},
		{KIND_FREE,  16'hAAAA, 16'h0000, 1'b1, ST_DONE,      16'h0000},
		{KIND_FREE,  16'h0000, 16'h0000, 1'b1, ST_DONE,      16'h0000},
		{KIND_FREE,  16'h0000, 16'h0000, 1'b1, ST_NOT_FOUND, 16'h0000},
		{KIND_ALLOC, 16'h0000, 16'h0000, 1'b1, ST_DONE,      16'h0000},
		{KIND_ALLOC, 16'h8000, 16'h0000, 1'b1, ST_DONE,      16'h0000},
		{KIND_ALLOC, 16'h8000, 16'h0000, 1'b0, ST_DONE,      16'h0000},
		{KIND_ALLOC, 16'h0001, 16'h0000, 1'b1, ST_NO_FIT,    16'h0000},
		{KIND_FREE,  16'h0000, 16'h8000, 1'b0, ST_DONE,      16'h0000},
		{KIND_FREE,  16'h0000, 16'h0000, 1'b0, ST_DONE,      16'h0000},
		{KIND_FREE,  16'h0000, 16'h0000, 1'b0, ST_DONE,      16'h0000},
		{KIND_ALLOC, 16'hFFFF, 16'h0000, 1'b1, ST_DONE,      16'h0000},
		{KIND_ALLOC, 16'h0002, 16'h0000, 1'b1, ST_NO_FIT,    16'h0000},
		{KIND_FREE,  16'hFFFF, 16'hFFFF, 1'b0, ST_DONE,      16'h0000},
		{KIND_FREE,  16'h0000, 16'h0000, 1'b1, ST_DONE,      16'h0000},
		{KIND_ALLOC, 16'h0000, 16'hFFFF, 1'b0, ST_DONE,      16'h0000},
		{KIND_FREE,  16'h1234, 16'h0001, 1'b0, ST_DONE,      16'h0000}
	};

	table_heap_allocator_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.request_size(request_size),
		.block_address(block_address),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.granted_address(granted_address)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic alloc_result_t allocator_outcome(input logic op, input logic [15:0] req,
			input logic [15:0] adr);
		alloc_result_t res;
		logic [SUM_W-1:0] sum;
		logic [SUM_W-1:0] stop;
		res.status = (op == KIND_ALLOC) ? ST_NO_FIT : ST_NOT_FOUND;
		res.granted = 16'h0000;
		if (op == KIND_ALLOC) begin
			for (int i = 0; i < TABLE_ENTRIES - 1; i++) begin
				if (!desc_free[i])
					continue;
				if (i != 0) begin
					sum = SUM_W'(desc_base[i-1]) + SUM_W'(desc_len[i-1]);
					desc_base[i] = (sum > SUM_W'(BASE_MAX)) ? BASE_MAX : sum[BASE_W-1:0];
				end
				stop = SUM_W'(desc_base[i]) + SUM_W'(req);
				if ((desc_free[i+1] || SUM_W'(desc_base[i+1]) >= stop) &&
						SUM_W'(desc_base[i]) < POOL_LIM && stop <= POOL_LIM) begin
					desc_len[i] = req;
					desc_free[i] = 1'b0;
					res.status = ST_DONE;
					res.granted = desc_base[i][15:0];
					return res;
				end
			end
		end else begin
			for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
				if (!desc_free[i] && desc_base[i] == BASE_W'(adr)) begin
					desc_free[i] = 1'b1;
					res.status = ST_DONE;
					return res;
				end
			end
		end
		return res;
	endfunction

	task automatic offer_item(input logic op, input logic [15:0] req, input logic [15:0] adr,
			input known_answer_t answer);
		fixed_answers.push_back(answer);
		kind <= op;
		request_size <= req;
		block_address <= adr;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall !== 1'b0);
		if (!quiet_tail && sender_idles && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
	endtask

	always @(posedge clk) begin : scoreboard
		alloc_result_t want;
		alloc_result_t pred;
		known_answer_t fixed;
		bit moved;
		if (arst_n) begin
			moved = 1'b0;
			if (in_valid && !in_stall) begin
				moved = 1'b1;
				pred = allocator_outcome(kind, request_size, block_address);
				fixed = fixed_answers.pop_front();
				awaited_results.push_back(fixed.known ? fixed.val : pred);
			end
			if (out_valid && !out_stall) begin
				moved = 1'b1;
				results_seen++;
				if (awaited_results.size() == 0) begin
					mismatch_count++;
					$display("%0t: result with none expected, got status %0d address %h",
						$time, status, granted_address);
				end else begin
					want = awaited_results.pop_front();
					if (status !== want.status || granted_address !== want.granted) begin
						mismatch_count++;
						$display("%0t: result %0d expected status %0d address %h, got status %0d address %h",
							$time, results_seen, want.status, want.granted, status, granted_address);
					end
				end
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin : receiver
		bit held;
		bit stalls_on;
		held = 1'b0;
		stalls_on = 1'b1;
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 99) == 0)
				stalls_on = !stalls_on;
			if (!held && results_seen >= 120) begin
				held = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else if (!quiet_tail && stalls_on && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 13)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	initial begin : stimulus
		known_answer_t answer;
		logic [15:0] live_bases[$];
		logic op;
		logic [15:0] req;
		logic [15:0] adr;
		int alloc_pct;
		int pick;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		kind <= KIND_ALLOC;
		request_size <= 16'h0000;
		block_address <= 16'h0000;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			desc_base[i] = '0;
			desc_len[i] = '0;
			desc_free[i] = 1'b1;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_script[r]) begin
			answer.known = directed_script[r].known;
			answer.val.status = directed_script[r].st;
			answer.val.granted = directed_script[r].ga;
			offer_item(directed_script[r].op, directed_script[r].req, directed_script[r].adr,
				answer);
		end

		answer = '0;
		alloc_pct = 55;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 40 == 0) begin
				pick = $urandom_range(0, 2);
				alloc_pct = (pick == 0) ? 30 : (pick == 1) ? 55 : 85;
				sender_idles = ($urandom_range(0, 3) != 0);
			end
			if (n >= RANDOM_ITEMS - QUIET_ITEMS)
				quiet_tail = 1'b1;
			req = 16'($urandom);
			adr = 16'($urandom);
			if ($urandom_range(0, 99) < alloc_pct) begin
				op = KIND_ALLOC;
				pick = $urandom_range(0, 99);
				if (pick < 10)
					req = 16'h0000;
				else if (pick < 50)
					req = 16'($urandom_range(1, 64));
				else if (pick < 80)
					req = 16'($urandom_range(0, 4095));
			end else begin
				op = KIND_FREE;
				live_bases.delete();
				for (int i = 0; i < TABLE_ENTRIES; i++)
					if (!desc_free[i] && desc_base[i] < BASE_W'(POOL_BYTES))
						live_bases.push_back(desc_base[i][15:0]);
				pick = $urandom_range(0, 99);
				if (pick < 75 && live_bases.size() != 0)
					adr = live_bases[$urandom_range(0, live_bases.size() - 1)];
				else if (pick < 88)
					adr = 16'($urandom_range(0, 255));
			end
			offer_item(op, req, adr, answer);
		end
		in_valid <= 1'b0;

		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && awaited_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

>>> files.f
sv/thau_pkg.sv
sv/thau_ram.sv
sv/table_heap_allocator_unit.sv
bench/table_heap_allocator_unit_tb.sv
